// ----- rtl/core/quaternion_slerp_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion SLERP core
// Clocked assertion wrappers used by the core to check its own logic.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_SLERP_CORE_MACROS_SVH
`define QUATERNION_SLERP_CORE_MACROS_SVH

// Implication or plain property, checked on every clock outside reset.
`define QS_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define QS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/qslerp_pkg.sv -----
// ----------------------------------------------------------------------------
// Quaternion SLERP package
// Payload types, internal widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package qslerp_pkg;

    // Default CORDIC length and the size of the arctangent table.
    localparam int CORDIC_STEPS_DEFAULT = 16;
    localparam int ATAN_LEN             = 24;

    // Internal widths.
    localparam int CORDIC_W    = 34;
    localparam int SQRT_STEPS  = 31;
    localparam int SQRT_TOP    = 2 * (SQRT_STEPS - 1);
    localparam int SQRT_N_W    = 61;
    localparam int SQRT_R_W    = 62;
    localparam int SIN_W       = 31;
    localparam int DOT_W       = 34;
    localparam int ABS_W       = 33;
    localparam int WEIGHT_BITS = 24;
    localparam int REM_W       = 55;
    localparam int PHI_W       = 47;

    localparam logic [CORDIC_W-1:0] CORDIC_K_Q30 = 34'd652032874;
    localparam logic [14:0]         THRESH_RESET = 15'd16376;
    localparam logic [14:0]         ONE_Q14      = 15'd16384;

    typedef struct packed {
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] start_z;
        logic signed [15:0] start_w;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic signed [15:0] end_z;
        logic signed [15:0] end_w;
        logic        [14:0] fraction;
    } in_t;

    typedef struct packed {
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic signed [15:0] out_w;
        logic               linear_used;
    } out_t;

    // Data that travels beside the arithmetic cells.
    typedef struct packed {
        logic [3:0][16:0]   a;
        logic [3:0][15:0]   b;
        logic [14:0]        t;
        logic               lin;
        logic [29:0]        c;
        logic [SIN_W-1:0]   s;
        logic [1:0]         ovf;
    } side_t;

    // Arctangent of 2^-idx in Q30 radians.
    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0:       v = 30'd843314857;
            1:       v = 30'd497837829;
            2:       v = 30'd263043837;
            3:       v = 30'd133525159;
            4:       v = 30'd67021687;
            5:       v = 30'd33543516;
            6:       v = 30'd16775851;
            7:       v = 30'd8388437;
            8:       v = 30'd4194283;
            9:       v = 30'd2097149;
            10:      v = 30'd1048576;
            11:      v = 30'd524288;
            12:      v = 30'd262144;
            13:      v = 30'd131072;
            14:      v = 30'd65536;
            15:      v = 30'd32768;
            16:      v = 30'd16384;
            17:      v = 30'd8192;
            18:      v = 30'd4096;
            19:      v = 30'd2048;
            20:      v = 30'd1024;
            21:      v = 30'd512;
            22:      v = 30'd256;
            23:      v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/qslerp_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step of the integer square root, one result bit per cell.
// ----------------------------------------------------------------------------
module qslerp_sqrt_cell #(
    parameter int BIT_POS = qslerp_pkg::SQRT_TOP
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [qslerp_pkg::SQRT_N_W-1:0]  n_in,
    input  logic [qslerp_pkg::SQRT_R_W-1:0]  r_in,
    output logic [qslerp_pkg::SQRT_N_W-1:0]  n_out,
    output logic [qslerp_pkg::SQRT_R_W-1:0]  r_out
);

    localparam logic [qslerp_pkg::SQRT_R_W-1:0] BIT_VAL =
        qslerp_pkg::SQRT_R_W'(1) << BIT_POS;

    logic [qslerp_pkg::SQRT_R_W-1:0] trial;
    logic [qslerp_pkg::SQRT_R_W-1:0] n_ext;
    logic [qslerp_pkg::SQRT_R_W-1:0] n_diff;
    logic                            take;
    logic [qslerp_pkg::SQRT_N_W-1:0] n_next;
    logic [qslerp_pkg::SQRT_R_W-1:0] r_next;
    logic [qslerp_pkg::SQRT_N_W-1:0] n_reg;
    logic [qslerp_pkg::SQRT_R_W-1:0] r_reg;

    // Trial subtraction of the partial root plus the current bit.
    assign trial  = r_in + BIT_VAL;
    assign n_ext  = {1'b0, n_in};
    assign take   = (n_ext >= trial);
    assign n_diff = n_ext - trial;

    always_comb begin
        if (take) begin
            n_next = n_diff[qslerp_pkg::SQRT_N_W-1:0];
            r_next = (r_in >> 1) + BIT_VAL;
        end else begin
            n_next = n_in;
            r_next = r_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= n_next;
            r_reg <= r_next;
        end
    end

    assign n_out = n_reg;
    assign r_out = r_reg;

endmodule

// ----- rtl/core/qslerp_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation, in vectoring or rotation mode, with a fixed shift.
// ----------------------------------------------------------------------------
module qslerp_cordic_cell #(
    parameter bit VECTORING = 1'b0,
    parameter int SHIFT     = 0
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [qslerp_pkg::CORDIC_W-1:0] x_in,
    input  logic signed [qslerp_pkg::CORDIC_W-1:0] y_in,
    input  logic signed [qslerp_pkg::CORDIC_W-1:0] z_in,
    output logic signed [qslerp_pkg::CORDIC_W-1:0] x_out,
    output logic signed [qslerp_pkg::CORDIC_W-1:0] y_out,
    output logic signed [qslerp_pkg::CORDIC_W-1:0] z_out
);

    localparam logic signed [qslerp_pkg::CORDIC_W-1:0] ANGLE =
        $signed({{(qslerp_pkg::CORDIC_W-30){1'b0}}, qslerp_pkg::atan_q30(SHIFT)});

    logic signed [qslerp_pkg::CORDIC_W-1:0] xs;
    logic signed [qslerp_pkg::CORDIC_W-1:0] ys;
    logic                                   pos;
    logic signed [qslerp_pkg::CORDIC_W-1:0] x_next;
    logic signed [qslerp_pkg::CORDIC_W-1:0] y_next;
    logic signed [qslerp_pkg::CORDIC_W-1:0] z_next;
    logic signed [qslerp_pkg::CORDIC_W-1:0] x_reg;
    logic signed [qslerp_pkg::CORDIC_W-1:0] y_reg;
    logic signed [qslerp_pkg::CORDIC_W-1:0] z_reg;

    assign xs = x_in >>> SHIFT;
    assign ys = y_in >>> SHIFT;

    // Vectoring drives y toward zero; rotation drives z toward zero.
    assign pos = VECTORING ? y_in[qslerp_pkg::CORDIC_W-1] : !z_in[qslerp_pkg::CORDIC_W-1];

    always_comb begin
        if (pos) begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ANGLE;
        end else begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ANGLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ----- rtl/core/qslerp_div_cell.sv -----
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step that settles one quotient bit.
// ----------------------------------------------------------------------------
module qslerp_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [qslerp_pkg::REM_W-1:0]        r_in,
    input  logic [qslerp_pkg::WEIGHT_BITS-1:0]  q_in,
    input  logic [qslerp_pkg::SIN_W-1:0]        d_in,
    output logic [qslerp_pkg::REM_W-1:0]        r_out,
    output logic [qslerp_pkg::WEIGHT_BITS-1:0]  q_out
);

    localparam logic [qslerp_pkg::WEIGHT_BITS-1:0] QBIT =
        qslerp_pkg::WEIGHT_BITS'(1) << SHIFT;

    logic [qslerp_pkg::REM_W-1:0]       trial;
    logic                               take;
    logic [qslerp_pkg::REM_W-1:0]       r_next;
    logic [qslerp_pkg::WEIGHT_BITS-1:0] q_next;
    logic [qslerp_pkg::REM_W-1:0]       r_reg;
    logic [qslerp_pkg::WEIGHT_BITS-1:0] q_reg;

    // Compare the remainder with the divisor aligned to this bit.
    assign trial = qslerp_pkg::REM_W'(d_in) << SHIFT;
    assign take  = (r_in >= trial);

    always_comb begin
        if (take) begin
            r_next = r_in - trial;
            q_next = q_in | QBIT;
        end else begin
            r_next = r_in;
            q_next = q_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg <= r_next;
            q_reg <= q_next;
        end
    end

    assign r_out = r_reg;
    assign q_out = q_reg;

endmodule

// ----- rtl/core/quaternion_slerp_core.sv -----
// ----------------------------------------------------------------------------
// Quaternion SLERP core
// Fully pipelined spherical linear interpolation with a linear fallback.
// ----------------------------------------------------------------------------
// The core accepts one quaternion pair and blend fraction per clock while
// s_ready is high and returns one blended quaternion per request, in order.
// The pipeline is built from chains of cells: 31 square root cells for
// sin(theta), two CORDIC chains of CORDIC_STEPS cells (angle, then both sines
// side by side), and 24 divider cells for the weights, plus ten single stages
// for the products, dot product, threshold, square root operand, angle
// scaling, divider setup, weight select, weighting, rounding and the output
// register. The whole pipeline advances together and stalls only when the
// output register is held and the last stage is full. The near threshold
// register is written through the cfg port, which is always ready; write it
// only while the core is idle.
`include "quaternion_slerp_core_macros.svh"

module quaternion_slerp_core #(
    parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  qslerp_pkg::in_t    s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output qslerp_pkg::out_t   m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [14:0]        cfg_data
);

    localparam int CW = qslerp_pkg::CORDIC_W;
    localparam int NQ = qslerp_pkg::SQRT_STEPS;
    localparam int WB = qslerp_pkg::WEIGHT_BITS;
    localparam logic [WB-1:0] WMAX = WB'(1) << (WB - 1);

    // Round and saturate a Q20 accumulator to a signed 16-bit component.
    function automatic logic signed [15:0] round_sat(input logic signed [42:0] acc);
        logic signed [42:0] r;
        logic signed [22:0] sh;
        logic signed [15:0] res;
        r  = acc + 43'sd524288;
        sh = 23'(r >>> 20);
        if (sh > 23'sd32767) begin
            res = 16'sh7fff;
        end else if (sh < -23'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = sh[15:0];
        end
        return res;
    endfunction

    logic en;
    logic [14:0] thr_reg;

    // Configuration register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= qslerp_pkg::THRESH_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: component products and fraction clamp.
    // ------------------------------------------------------------------
    logic signed [15:0] in_a [4];
    logic signed [15:0] in_b [4];
    logic               v1_reg;
    qslerp_pkg::side_t  side1_reg;
    logic signed [31:0] prod1_reg [4];

    assign in_a[0] = s_data.start_x;
    assign in_a[1] = s_data.start_y;
    assign in_a[2] = s_data.start_z;
    assign in_a[3] = s_data.start_w;
    assign in_b[0] = s_data.end_x;
    assign in_b[1] = s_data.end_y;
    assign in_b[2] = s_data.end_z;
    assign in_b[3] = s_data.end_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                side1_reg.a[k] <= {in_a[k][15], in_a[k]};
                side1_reg.b[k] <= in_b[k];
                prod1_reg[k]   <= in_a[k] * in_b[k];
            end
            side1_reg.t   <= (s_data.fraction > qslerp_pkg::ONE_Q14) ?
                             qslerp_pkg::ONE_Q14 : s_data.fraction;
            side1_reg.lin <= 1'b0;
            side1_reg.c   <= '0;
            side1_reg.s   <= '0;
            side1_reg.ovf <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: dot product and hemisphere correction.
    // ------------------------------------------------------------------
    logic signed [qslerp_pkg::DOT_W-1:0] dot_sum;
    logic                                dot_neg;
    qslerp_pkg::side_t                   side2_next;
    logic                                v2_reg;
    qslerp_pkg::side_t                   side2_reg;
    logic [qslerp_pkg::ABS_W-1:0]        abs2_reg;

    assign dot_sum = qslerp_pkg::DOT_W'(prod1_reg[0]) + qslerp_pkg::DOT_W'(prod1_reg[1])
                   + qslerp_pkg::DOT_W'(prod1_reg[2]) + qslerp_pkg::DOT_W'(prod1_reg[3]);
    assign dot_neg = dot_sum[qslerp_pkg::DOT_W-1];

    // Flip the start quaternion into the same hemisphere as the end one.
    always_comb begin
        side2_next = side1_reg;
        for (int k = 0; k < 4; k++) begin
            side2_next.a[k] = dot_neg ? 17'(-$signed(side1_reg.a[k])) : side1_reg.a[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side2_reg <= side2_next;
            abs2_reg  <= dot_neg ? qslerp_pkg::ABS_W'(-dot_sum) : qslerp_pkg::ABS_W'(dot_sum);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: path select and cos(theta) squared.
    // ------------------------------------------------------------------
    logic        lin3;
    logic [29:0] c3;
    qslerp_pkg::side_t side3_next;
    logic        v3_reg;
    qslerp_pkg::side_t side3_reg;
    logic [59:0] csq3_reg;

    assign lin3 = (abs2_reg >= {4'd0, thr_reg, 14'd0}) || (abs2_reg >= 33'h010000000);
    assign c3   = lin3 ? 30'd0 : {abs2_reg[27:0], 2'b00};

    always_comb begin
        side3_next     = side2_reg;
        side3_next.lin = lin3;
        side3_next.c   = c3;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side3_reg <= side3_next;
            csq3_reg  <= 60'(c3) * 60'(c3);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sin(theta) squared as the square root operand.
    // ------------------------------------------------------------------
    logic              v4_reg;
    qslerp_pkg::side_t side4_reg;
    logic [qslerp_pkg::SQRT_N_W-1:0] n4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side4_reg <= side3_reg;
            n4_reg    <= (qslerp_pkg::SQRT_N_W'(1) << 60) - {1'b0, csq3_reg};
        end
    end

    // ------------------------------------------------------------------
    // Square root chain.
    // ------------------------------------------------------------------
    logic [qslerp_pkg::SQRT_N_W-1:0] sq_n [NQ];
    logic [qslerp_pkg::SQRT_R_W-1:0] sq_r [NQ];
    logic                            sq_v_reg [NQ];
    qslerp_pkg::side_t               sq_side_reg [NQ];

    for (genvar i = 0; i < NQ; i++) begin : g_sqrt
        logic [qslerp_pkg::SQRT_N_W-1:0] n_in;
        logic [qslerp_pkg::SQRT_R_W-1:0] r_in;
        logic                            v_in;
        qslerp_pkg::side_t               side_in;

        if (i == 0) begin : g_head
            assign n_in    = n4_reg;
            assign r_in    = '0;
            assign v_in    = v4_reg;
            assign side_in = side4_reg;
        end else begin : g_link
            assign n_in    = sq_n[i-1];
            assign r_in    = sq_r[i-1];
            assign v_in    = sq_v_reg[i-1];
            assign side_in = sq_side_reg[i-1];
        end

        qslerp_sqrt_cell #(
            .BIT_POS (qslerp_pkg::SQRT_TOP - 2 * i)
        ) u_cell (
            .aclk  (aclk),
            .en    (en),
            .n_in  (n_in),
            .r_in  (r_in),
            .n_out (sq_n[i]),
            .r_out (sq_r[i])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_v_reg[i] <= 1'b0;
            end else if (en) begin
                sq_v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_side_reg[i] <= side_in;
            end
        end
    end

    logic [qslerp_pkg::SIN_W-1:0] s_val;
    qslerp_pkg::side_t            sq_side_out;

    assign s_val = sq_r[NQ-1][qslerp_pkg::SIN_W-1:0];
    always_comb begin
        sq_side_out   = sq_side_reg[NQ-1];
        sq_side_out.s = s_val;
    end

    // ------------------------------------------------------------------
    // Vectoring CORDIC chain: theta = atan2(sin, cos).
    // ------------------------------------------------------------------
    logic signed [CW-1:0] vx [CORDIC_STEPS];
    logic signed [CW-1:0] vy [CORDIC_STEPS];
    logic signed [CW-1:0] vz [CORDIC_STEPS];
    logic                 vc_v_reg [CORDIC_STEPS];
    qslerp_pkg::side_t    vc_side_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [CW-1:0] z_in;
        logic                 v_in;
        qslerp_pkg::side_t    side_in;

        if (i == 0) begin : g_head
            assign x_in    = $signed({{(CW-30){1'b0}}, sq_side_reg[NQ-1].c});
            assign y_in    = $signed({{(CW-qslerp_pkg::SIN_W){1'b0}}, s_val});
            assign z_in    = '0;
            assign v_in    = sq_v_reg[NQ-1];
            assign side_in = sq_side_out;
        end else begin : g_link
            assign x_in    = vx[i-1];
            assign y_in    = vy[i-1];
            assign z_in    = vz[i-1];
            assign v_in    = vc_v_reg[i-1];
            assign side_in = vc_side_reg[i-1];
        end

        qslerp_cordic_cell #(
            .VECTORING (1'b1),
            .SHIFT     (i)
        ) u_cell (
            .aclk  (aclk),
            .en    (en),
            .x_in  (x_in),
            .y_in  (y_in),
            .z_in  (z_in),
            .x_out (vx[i]),
            .y_out (vy[i]),
            .z_out (vz[i])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vc_v_reg[i] <= 1'b0;
            end else if (en) begin
                vc_v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                vc_side_reg[i] <= side_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Angle stage: t * theta and (1 - t) * theta.
    // ------------------------------------------------------------------
    logic [31:0]                 theta;
    logic                        ph_v_reg;
    qslerp_pkg::side_t           ph_side_reg;
    logic [qslerp_pkg::PHI_W-1:0] ph0_reg;
    logic [qslerp_pkg::PHI_W-1:0] ph1_reg;
    logic [14:0]                 t_rest;

    assign theta  = vz[CORDIC_STEPS-1][CW-1] ? 32'd0 : vz[CORDIC_STEPS-1][31:0];
    assign t_rest = qslerp_pkg::ONE_Q14 - vc_side_reg[CORDIC_STEPS-1].t;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_v_reg <= 1'b0;
        end else if (en) begin
            ph_v_reg <= vc_v_reg[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_side_reg <= vc_side_reg[CORDIC_STEPS-1];
            ph0_reg     <= qslerp_pkg::PHI_W'(t_rest) * qslerp_pkg::PHI_W'(theta);
            ph1_reg     <= qslerp_pkg::PHI_W'(vc_side_reg[CORDIC_STEPS-1].t)
                         * qslerp_pkg::PHI_W'(theta);
        end
    end

    // ------------------------------------------------------------------
    // Rotation CORDIC chains: sines of both partial angles side by side.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] rx0 [CORDIC_STEPS];
    logic signed [CW-1:0] ry0 [CORDIC_STEPS];
    logic signed [CW-1:0] rz0 [CORDIC_STEPS];
    logic signed [CW-1:0] rx1 [CORDIC_STEPS];
    logic signed [CW-1:0] ry1 [CORDIC_STEPS];
    logic signed [CW-1:0] rz1 [CORDIC_STEPS];
    logic                 rc_v_reg [CORDIC_STEPS];
    qslerp_pkg::side_t    rc_side_reg [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        logic signed [CW-1:0] x0_in;
        logic signed [CW-1:0] y0_in;
        logic signed [CW-1:0] z0_in;
        logic signed [CW-1:0] x1_in;
        logic signed [CW-1:0] y1_in;
        logic signed [CW-1:0] z1_in;
        logic                 v_in;
        qslerp_pkg::side_t    side_in;

        if (i == 0) begin : g_head
            assign x0_in   = $signed(qslerp_pkg::CORDIC_K_Q30);
            assign y0_in   = '0;
            assign z0_in   = $signed({1'b0, ph0_reg[qslerp_pkg::PHI_W-1:14]});
            assign x1_in   = $signed(qslerp_pkg::CORDIC_K_Q30);
            assign y1_in   = '0;
            assign z1_in   = $signed({1'b0, ph1_reg[qslerp_pkg::PHI_W-1:14]});
            assign v_in    = ph_v_reg;
            assign side_in = ph_side_reg;
        end else begin : g_link
            assign x0_in   = rx0[i-1];
            assign y0_in   = ry0[i-1];
            assign z0_in   = rz0[i-1];
            assign x1_in   = rx1[i-1];
            assign y1_in   = ry1[i-1];
            assign z1_in   = rz1[i-1];
            assign v_in    = rc_v_reg[i-1];
            assign side_in = rc_side_reg[i-1];
        end

        qslerp_cordic_cell #(
            .VECTORING (1'b0),
            .SHIFT     (i)
        ) u_cell0 (
            .aclk  (aclk),
            .en    (en),
            .x_in  (x0_in),
            .y_in  (y0_in),
            .z_in  (z0_in),
            .x_out (rx0[i]),
            .y_out (ry0[i]),
            .z_out (rz0[i])
        );

        qslerp_cordic_cell #(
            .VECTORING (1'b0),
            .SHIFT     (i)
        ) u_cell1 (
            .aclk  (aclk),
            .en    (en),
            .x_in  (x1_in),
            .y_in  (y1_in),
            .z_in  (z1_in),
            .x_out (rx1[i]),
            .y_out (ry1[i]),
            .z_out (rz1[i])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rc_v_reg[i] <= 1'b0;
            end else if (en) begin
                rc_v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rc_side_reg[i] <= side_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider setup: rounded numerators and the overflow check.
    // ------------------------------------------------------------------
    logic [32:0]                  sin0_c;
    logic [32:0]                  sin1_c;
    logic [qslerp_pkg::REM_W-1:0] num0;
    logic [qslerp_pkg::REM_W-1:0] num1;
    logic [qslerp_pkg::REM_W-1:0] dlim;
    logic [qslerp_pkg::SIN_W-1:0] s_rot;
    qslerp_pkg::side_t            dp_side_next;
    logic                         dp_v_reg;
    qslerp_pkg::side_t            dp_side_reg;
    logic [qslerp_pkg::REM_W-1:0] dp_r0_reg;
    logic [qslerp_pkg::REM_W-1:0] dp_r1_reg;

    assign s_rot  = rc_side_reg[CORDIC_STEPS-1].s;
    assign sin0_c = ry0[CORDIC_STEPS-1][CW-1] ? 33'd0 : ry0[CORDIC_STEPS-1][32:0];
    assign sin1_c = ry1[CORDIC_STEPS-1][CW-1] ? 33'd0 : ry1[CORDIC_STEPS-1][32:0];
    assign num0   = (qslerp_pkg::REM_W'(sin0_c) << 20) + qslerp_pkg::REM_W'(s_rot >> 1);
    assign num1   = (qslerp_pkg::REM_W'(sin1_c) << 20) + qslerp_pkg::REM_W'(s_rot >> 1);
    assign dlim   = qslerp_pkg::REM_W'(s_rot) << WB;

    always_comb begin
        dp_side_next        = rc_side_reg[CORDIC_STEPS-1];
        dp_side_next.ovf[0] = (num0 >= dlim);
        dp_side_next.ovf[1] = (num1 >= dlim);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dp_v_reg <= 1'b0;
        end else if (en) begin
            dp_v_reg <= rc_v_reg[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dp_side_reg <= dp_side_next;
            dp_r0_reg   <= num0;
            dp_r1_reg   <= num1;
        end
    end

    // ------------------------------------------------------------------
    // Divider chain: both weights, one quotient bit per cell.
    // ------------------------------------------------------------------
    logic [qslerp_pkg::REM_W-1:0] dr0 [WB];
    logic [qslerp_pkg::REM_W-1:0] dr1 [WB];
    logic [WB-1:0]                dq0 [WB];
    logic [WB-1:0]                dq1 [WB];
    logic                         dv_v_reg [WB];
    qslerp_pkg::side_t            dv_side_reg [WB];

    for (genvar i = 0; i < WB; i++) begin : g_div
        logic [qslerp_pkg::REM_W-1:0] r0_in;
        logic [qslerp_pkg::REM_W-1:0] r1_in;
        logic [WB-1:0]                q0_in;
        logic [WB-1:0]                q1_in;
        logic                         v_in;
        qslerp_pkg::side_t            side_in;

        if (i == 0) begin : g_head
            assign r0_in   = dp_r0_reg;
            assign r1_in   = dp_r1_reg;
            assign q0_in   = '0;
            assign q1_in   = '0;
            assign v_in    = dp_v_reg;
            assign side_in = dp_side_reg;
        end else begin : g_link
            assign r0_in   = dr0[i-1];
            assign r1_in   = dr1[i-1];
            assign q0_in   = dq0[i-1];
            assign q1_in   = dq1[i-1];
            assign v_in    = dv_v_reg[i-1];
            assign side_in = dv_side_reg[i-1];
        end

        qslerp_div_cell #(
            .SHIFT (WB - 1 - i)
        ) u_cell0 (
            .aclk  (aclk),
            .en    (en),
            .r_in  (r0_in),
            .q_in  (q0_in),
            .d_in  (side_in.s),
            .r_out (dr0[i]),
            .q_out (dq0[i])
        );

        qslerp_div_cell #(
            .SHIFT (WB - 1 - i)
        ) u_cell1 (
            .aclk  (aclk),
            .en    (en),
            .r_in  (r1_in),
            .q_in  (q1_in),
            .d_in  (side_in.s),
            .r_out (dr1[i]),
            .q_out (dq1[i])
        );

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[i] <= 1'b0;
            end else if (en) begin
                dv_v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_side_reg[i] <= side_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Weight stage: saturate quotients, or take the linear weights.
    // ------------------------------------------------------------------
    qslerp_pkg::side_t dv_last;
    logic [14:0]       t_last_rest;
    logic [WB-1:0]     w0_next;
    logic [WB-1:0]     w1_next;
    logic              wt_v_reg;
    qslerp_pkg::side_t wt_side_reg;
    logic [WB-1:0]     w0_reg;
    logic [WB-1:0]     w1_reg;

    assign dv_last     = dv_side_reg[WB-1];
    assign t_last_rest = qslerp_pkg::ONE_Q14 - dv_last.t;

    always_comb begin
        if (dv_last.lin) begin
            w0_next = {{(WB-21){1'b0}}, t_last_rest, 6'd0};
            w1_next = {{(WB-21){1'b0}}, dv_last.t, 6'd0};
        end else begin
            w0_next = (dv_last.ovf[0] || (dq0[WB-1] > WMAX)) ? WMAX : dq0[WB-1];
            w1_next = (dv_last.ovf[1] || (dq1[WB-1] > WMAX)) ? WMAX : dq1[WB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wt_v_reg <= 1'b0;
        end else if (en) begin
            wt_v_reg <= dv_v_reg[WB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wt_side_reg <= dv_last;
            w0_reg      <= w0_next;
            w1_reg      <= w1_next;
        end
    end

    // ------------------------------------------------------------------
    // Multiply stage: weighted components, four lanes.
    // ------------------------------------------------------------------
    logic              mu_v_reg;
    logic              mu_lin_reg;
    logic signed [41:0] pa_reg [4];
    logic signed [41:0] pb_reg [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mu_v_reg <= 1'b0;
        end else if (en) begin
            mu_v_reg <= wt_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mu_lin_reg <= wt_side_reg.lin;
            for (int k = 0; k < 4; k++) begin
                pa_reg[k] <= $signed({1'b0, w0_reg}) * $signed(wt_side_reg.a[k]);
                pb_reg[k] <= $signed({1'b0, w1_reg}) * $signed(wt_side_reg.b[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage: sum, round and saturate.
    // ------------------------------------------------------------------
    logic signed [15:0] comp [4];
    logic               p_v_reg;
    qslerp_pkg::out_t   p_data_reg;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            comp[k] = round_sat(43'(pa_reg[k]) + 43'(pb_reg[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_v_reg <= 1'b0;
        end else if (en) begin
            p_v_reg <= mu_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_data_reg.out_x       <= comp[0];
            p_data_reg.out_y       <= comp[1];
            p_data_reg.out_z       <= comp[2];
            p_data_reg.out_w       <= comp[3];
            p_data_reg.linear_used <= mu_lin_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register and pipeline advance.
    // ------------------------------------------------------------------
    logic             m_valid_reg;
    qslerp_pkg::out_t m_data_reg;

    assign en      = !p_v_reg || !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg <= p_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= p_data_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `QS_ASSERT_CLK(a_sin_nonzero, (sq_v_reg[NQ-1] && !sq_side_reg[NQ-1].lin) |-> (s_val != '0), "zero sine on the spherical path")
    `QS_ASSERT_CLK(a_weight_bound, wt_v_reg |-> ((w0_reg <= WMAX) && (w1_reg <= WMAX)), "weight above its limit")
    `QS_ASSERT_NEXT(a_last_hold, (p_v_reg && !en), (p_v_reg && $stable(p_data_reg)), "last stage lost a stalled request")
    `QS_ASSERT_NEXT(a_last_move, (p_v_reg && (!m_valid_reg || m_ready)), (m_valid_reg && (m_data_reg == $past(p_data_reg))), "result not moved to the output")

endmodule
